### rtl/core/sbe_pkg.sv
// Shared types and constants of the stack bytecode executor.
// Holds the opcode and status encodings and the decoded item passed front to back.
// No dependencies.
`default_nettype none
package sbe_pkg;

  typedef enum logic [5:0] {
    OP_START  = 6'd0,  OP_BYE   = 6'd1,  OP_ZERO  = 6'd2,  OP_ONE   = 6'd3,
    OP_LIT8   = 6'd4,  OP_LIT16 = 6'd5,  OP_S2D   = 6'd6,  OP_DROP  = 6'd7,
    OP_DUP    = 6'd8,  OP_SWAP  = 6'd9,  OP_OVER  = 6'd10, OP_ADD   = 6'd11,
    OP_SUB    = 6'd12, OP_AND   = 6'd13, OP_OR    = 6'd14, OP_INC   = 6'd15,
    OP_DEC    = 6'd16, OP_EQ    = 6'd17, OP_NE    = 6'd18, OP_ULT   = 6'd19,
    OP_ZEQ    = 6'd20, OP_JMP8  = 6'd21, OP_JZ8   = 6'd22, OP_JMP16 = 6'd23,
    OP_JZ16   = 6'd24, OP_CALL  = 6'd25, OP_EXIT  = 6'd26, OP_TOR   = 6'd27,
    OP_RFROM  = 6'd28, OP_RFETCH = 6'd29, OP_DLIT = 6'd30, OP_DDROP = 6'd31,
    OP_DADD   = 6'd32, OP_DSUB  = 6'd33, OP_DEQ   = 6'd34, OP_DULT  = 6'd35,
    OP_LGET   = 6'd36, OP_LSET  = 6'd37, OP_SLT   = 6'd38
  } op_t;

  localparam logic [5:0] OP_LAST = 6'd38;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_STACK  = 3'd2,
    ST_BOUNDS = 3'd3,
    ST_BADOP  = 3'd4
  } status_t;

  localparam logic [1:0] CFG_DATA_DEPTH   = 2'd0;
  localparam logic [1:0] CFG_RETURN_DEPTH = 2'd1;
  localparam logic [1:0] CFG_LOCALS_SIZE  = 2'd2;
  localparam logic [1:0] CFG_INIT_FRAME   = 2'd3;

  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [31:0] imm;
    logic [7:0]  cf;
    logic [15:0] ft;
  } exec_item_t;

endpackage
`default_nettype wire

### rtl/core/sbe_channels.sv
// Handshake channel interfaces of the stack bytecode executor.
// Instruction, result and configuration channels; no dependencies.
`default_nettype none
interface sbe_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  operation;
  logic [31:0] immediate;
  logic [7:0]  callee_frame;
  logic [15:0] fall_through;
  modport source(output valid, operation, immediate, callee_frame, fall_through, input ready);
  modport sink(input valid, operation, immediate, callee_frame, fall_through, output ready);
endinterface

interface sbe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_address;
  logic [2:0]  status;
  logic [15:0] top_value;
  modport source(output valid, next_address, status, top_value, input ready);
  modport sink(input valid, next_address, status, top_value, output ready);
endinterface

interface sbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/sbe_front.sv
// Front end: accepts instruction transactions, classifies the opcode and queues them.
// Depends on sbe_pkg and sbe_channels.
`default_nettype none
module sbe_front
  import sbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  sbe_in_if.sink          in_ch,
  output exec_item_t      q_item,
  output logic            q_valid,
  input  wire logic       q_pop
);

  exec_item_t buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  exec_item_t dec;

  always_comb begin
    dec.bad = in_ch.operation > OP_LAST;
    dec.op  = dec.bad ? OP_BYE : op_t'(in_ch.operation);
    dec.imm = in_ch.immediate;
    dec.cf  = in_ch.callee_frame;
    dec.ft  = in_ch.fall_through;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

### rtl/core/sbe_back.sv
// Back end: executes queued instructions on the stacks and the local store.
// Holds the configuration registers and the result register; depends on sbe_pkg and sbe_channels.
`default_nettype none
module sbe_back
  import sbe_pkg::*;
#(
  parameter int DATA_DEPTH   = 32,
  parameter int RETURN_DEPTH = 32,
  parameter int LOCAL_DEPTH  = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  exec_item_t      q_item,
  input  wire logic       q_valid,
  output logic            q_pop,
  sbe_out_if.source       out_ch,
  sbe_cfg_if.sink         cfg_ch
);

  localparam int DP_W = $clog2(DATA_DEPTH + 1);
  localparam int DA   = $clog2(DATA_DEPTH);
  localparam int RP_W = $clog2(RETURN_DEPTH + 1);
  localparam int RA   = $clog2(RETURN_DEPTH);
  localparam int LM_W = $clog2(LOCAL_DEPTH + 1);
  localparam int LA   = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;

  logic [5:0] ddu_r, rdu_r;
  logic [6:0] lsu_r, ifr_r;

  logic [15:0]     d_r  [DATA_DEPTH];
  logic [15:0]     rc_r [RETURN_DEPTH];
  logic [15:0]     lm_r [LOCAL_DEPTH];
  logic [15:0]     lrd_r;

  logic [DP_W-1:0] dp_r, dp_nxt, ds_lim_r, ds_lim_nxt, ds_cfg;
  logic [RP_W-1:0] rp_r, rp_nxt, rs_lim_r, rs_lim_nxt, rs_cfg;
  logic [LM_W-1:0] lv_lim_r, lv_lim_nxt, lv_cfg;
  logic [7:0]      fb_r, fb_nxt, ftop_r, ftop_nxt;
  status_t         halted_r, halted_nxt, st;
  logic [15:0]     cur_r, cur_nxt, nip;
  logic            wait_r, wait_nxt, issue, fire;

  logic            out_valid_r;
  logic [15:0]     out_addr_r, out_top_r, top_nxt, tv;
  status_t         out_st_r;

  logic [DP_W-1:0] p1, p2, p3, pm1, pm2;
  logic [DA-1:0]   i0, i1, i2, i3, im1, im2, itop;
  logic [15:0]     c0, c1, c2, c3, x16;
  logic [31:0]     xd, yd, rd;
  logic [8:0]      avail, idx, csum;
  logic            need1, need2, need4, can_push;
  logic [RA-1:0]   ri0, ri1, rim1, rim2;
  logic [15:0]     rtop;

  logic            dwe0, dwe1, rwe0, rwe1, lwe;
  logic [DA-1:0]   dwa0, dwa1;
  logic [15:0]     dwv0, dwv1, rwv0, rwv1;
  logic [RA-1:0]   rwa0, rwa1;

  assign cfg_ch.ready = 1'b1;

  assign ds_cfg = (9'(ddu_r) > 9'(DATA_DEPTH))   ? DP_W'(DATA_DEPTH)   : DP_W'(ddu_r);
  assign rs_cfg = (9'(rdu_r) > 9'(RETURN_DEPTH)) ? RP_W'(RETURN_DEPTH) : RP_W'(rdu_r);
  assign lv_cfg = (9'(lsu_r) > 9'(LOCAL_DEPTH))  ? LM_W'(LOCAL_DEPTH)  : LM_W'(lsu_r);

  always_comb begin
    p1   = dp_r + DP_W'(1);
    p2   = dp_r + DP_W'(2);
    p3   = dp_r + DP_W'(3);
    pm1  = dp_r - DP_W'(1);
    pm2  = dp_r - DP_W'(2);
    i0   = dp_r[DA-1:0];
    i1   = p1[DA-1:0];
    i2   = p2[DA-1:0];
    i3   = p3[DA-1:0];
    im1  = pm1[DA-1:0];
    im2  = pm2[DA-1:0];
    c0   = d_r[i0];
    c1   = d_r[i1];
    c2   = d_r[i2];
    c3   = d_r[i3];
    avail = 9'(ds_lim_r - dp_r);
    need1 = avail >= 9'd1;
    need2 = avail >= 9'd2;
    need4 = avail >= 9'd4;
    can_push = (dp_r != '0) && (dp_r <= ds_lim_r);
    ri0  = rp_r[RA-1:0];
    ri1  = RA'(rp_r + RP_W'(1));
    rim1 = RA'(rp_r - RP_W'(1));
    rim2 = RA'(rp_r - RP_W'(2));
    rtop = rc_r[rim1];
    idx  = 9'(fb_r) + 9'(q_item.imm[7:0]);
    csum = 9'(ftop_r) + 9'(q_item.cf);
    yd   = {c0, c1};
    xd   = {c2, c3};
  end

  assign issue = q_valid && !wait_r && (halted_r == ST_RUN) && !q_item.bad &&
                 (q_item.op == OP_LGET) && (idx < 9'(lv_lim_r));
  assign fire  = q_valid && !issue && (!out_valid_r || out_ch.ready);
  assign q_pop = fire;

  always_comb begin
    dp_nxt = dp_r;  rp_nxt = rp_r;  fb_nxt = fb_r;  ftop_nxt = ftop_r;
    ds_lim_nxt = ds_lim_r;  rs_lim_nxt = rs_lim_r;  lv_lim_nxt = lv_lim_r;
    halted_nxt = halted_r;  cur_nxt = cur_r;
    st = ST_RUN;  nip = q_item.ft;  x16 = '0;  rd = '0;
    dwe0 = 1'b0; dwe1 = 1'b0; dwa0 = i0; dwa1 = i1; dwv0 = '0; dwv1 = '0;
    rwe0 = 1'b0; rwe1 = 1'b0; rwa0 = ri0; rwa1 = ri1; rwv0 = '0; rwv1 = '0;
    lwe = 1'b0;
    if (!q_item.bad && q_item.op == OP_START) begin
      ds_lim_nxt = ds_cfg;  rs_lim_nxt = rs_cfg;  lv_lim_nxt = lv_cfg;
      dp_nxt = ds_cfg;  rp_nxt = '0;  fb_nxt = '0;  ftop_nxt = 8'(ifr_r);
      halted_nxt = ST_RUN;  cur_nxt = q_item.imm[15:0];
    end else if (halted_r == ST_RUN) begin
      if (q_item.bad) begin
        st = ST_BADOP;
      end else begin
        case (q_item.op)
          OP_BYE: st = need1 ? ST_DONE : ST_STACK;
          OP_ZERO, OP_S2D, OP_ONE, OP_LIT8, OP_LIT16, OP_DUP, OP_OVER: begin
            case (q_item.op)
              OP_ONE:   dwv0 = 16'd1;
              OP_LIT8:  dwv0 = {8'd0, q_item.imm[7:0]};
              OP_LIT16: dwv0 = q_item.imm[15:0];
              OP_DUP:   dwv0 = c0;
              OP_OVER:  dwv0 = c1;
              default:  dwv0 = 16'd0;
            endcase
            if (!can_push || (q_item.op == OP_DUP && !need1) ||
                (q_item.op == OP_OVER && !need2)) begin
              st = ST_STACK;
            end else begin
              dwe0 = 1'b1;  dwa0 = im1;  dp_nxt = pm1;
            end
          end
          OP_DROP: if (!need1) st = ST_STACK; else dp_nxt = p1;
          OP_SWAP: begin
            if (!need2) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = i0; dwv0 = c1;
              dwe1 = 1'b1; dwa1 = i1; dwv1 = c0;
            end
          end
          OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EQ, OP_NE, OP_ULT, OP_SLT: begin
            case (q_item.op)
              OP_ADD:  x16 = c1 + c0;
              OP_SUB:  x16 = c1 - c0;
              OP_AND:  x16 = c1 & c0;
              OP_OR:   x16 = c1 | c0;
              OP_EQ:   x16 = 16'(c1 == c0);
              OP_NE:   x16 = 16'(c1 != c0);
              OP_ULT:  x16 = 16'(c1 < c0);
              default: x16 = 16'((c1 ^ 16'h8000) < (c0 ^ 16'h8000));
            endcase
            if (!need2) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = i1; dwv0 = x16; dp_nxt = p1;
            end
          end
          OP_INC, OP_DEC, OP_ZEQ: begin
            case (q_item.op)
              OP_INC:  x16 = c0 + 16'd1;
              OP_DEC:  x16 = c0 - 16'd1;
              default: x16 = 16'(c0 == 16'd0);
            endcase
            if (!need1) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = i0; dwv0 = x16;
            end
          end
          OP_JMP8, OP_JZ8, OP_JMP16, OP_JZ16: begin
            if (q_item.op == OP_JMP8 || q_item.op == OP_JZ8)
              x16 = {{8{q_item.imm[7]}}, q_item.imm[7:0]};
            else
              x16 = q_item.imm[15:0];
            if (q_item.op == OP_JZ8 || q_item.op == OP_JZ16) begin
              if (!need1) st = ST_STACK;
              else begin
                dp_nxt = p1;
                if (c0 == 16'd0) nip = q_item.ft + x16;
              end
            end else begin
              nip = q_item.ft + x16;
            end
          end
          OP_CALL: begin
            if (9'(rp_r) + 9'd2 > 9'(rs_lim_r)) st = ST_STACK;
            else if (csum > 9'(lv_lim_r)) st = ST_BOUNDS;
            else begin
              rwe0 = 1'b1; rwa0 = ri0; rwv0 = q_item.ft;
              rwe1 = 1'b1; rwa1 = ri1; rwv1 = {8'd0, fb_r};
              rp_nxt = rp_r + RP_W'(2);
              fb_nxt = ftop_r;
              ftop_nxt = csum[7:0];
              nip = q_item.imm[15:0];
            end
          end
          OP_EXIT: begin
            if (rp_r == '0) st = need1 ? ST_DONE : ST_STACK;
            else if (rp_r < RP_W'(2)) st = ST_STACK;
            else begin
              ftop_nxt = fb_r;
              fb_nxt = rtop[7:0];
              nip = rc_r[rim2];
              rp_nxt = rp_r - RP_W'(2);
            end
          end
          OP_TOR: begin
            if (!need1) st = ST_STACK;
            else begin
              dp_nxt = p1;
              if (rp_r >= rs_lim_r) st = ST_STACK;
              else begin
                rwe0 = 1'b1; rwa0 = ri0; rwv0 = c0; rp_nxt = rp_r + RP_W'(1);
              end
            end
          end
          OP_RFROM, OP_RFETCH: begin
            if (rp_r == '0) st = ST_STACK;
            else begin
              if (q_item.op == OP_RFROM) rp_nxt = rp_r - RP_W'(1);
              if (!can_push) st = ST_STACK;
              else begin
                dwe0 = 1'b1; dwa0 = im1; dwv0 = rtop; dp_nxt = pm1;
              end
            end
          end
          OP_DLIT: begin
            if (!can_push) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = im1; dwv0 = q_item.imm[15:0]; dp_nxt = pm1;
              if (pm1 == '0) st = ST_STACK;
              else begin
                dwe1 = 1'b1; dwa1 = im2; dwv1 = q_item.imm[31:16]; dp_nxt = pm2;
              end
            end
          end
          OP_DDROP: if (!need2) st = ST_STACK; else dp_nxt = p2;
          OP_DADD, OP_DSUB: begin
            rd = (q_item.op == OP_DADD) ? xd + yd : xd - yd;
            if (!need4) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = i3; dwv0 = rd[15:0];
              dwe1 = 1'b1; dwa1 = i2; dwv1 = rd[31:16];
              dp_nxt = p2;
            end
          end
          OP_DEQ, OP_DULT: begin
            x16 = (q_item.op == OP_DEQ) ? 16'(xd == yd) : 16'(xd < yd);
            if (!need4) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = i3; dwv0 = x16; dp_nxt = p3;
            end
          end
          OP_LGET: begin
            if (idx >= 9'(lv_lim_r)) st = ST_BOUNDS;
            else if (!can_push) st = ST_STACK;
            else begin
              dwe0 = 1'b1; dwa0 = im1; dwv0 = lrd_r; dp_nxt = pm1;
            end
          end
          OP_LSET: begin
            if (idx >= 9'(lv_lim_r)) st = ST_BOUNDS;
            else if (!need1) st = ST_STACK;
            else begin
              lwe = 1'b1; dp_nxt = p1;
            end
          end
          default: st = ST_BADOP;
        endcase
      end
      if (st != ST_RUN) halted_nxt = st;
      else cur_nxt = nip;
    end
    itop = dp_nxt[DA-1:0];
    if (dwe1 && dwa1 == itop) tv = dwv1;
    else if (dwe0 && dwa0 == itop) tv = dwv0;
    else tv = d_r[itop];
    top_nxt = (dp_nxt < ds_lim_nxt) ? tv : 16'd0;
    wait_nxt = issue;
  end

  always_ff @(posedge clk) begin
    if (fire && dwe0) d_r[dwa0] <= dwv0;
    if (fire && dwe1) d_r[dwa1] <= dwv1;
    if (fire && rwe0) rc_r[rwa0] <= rwv0;
    if (fire && rwe1) rc_r[rwa1] <= rwv1;
  end

  always_ff @(posedge clk) begin
    if (fire && lwe) lm_r[idx[LA-1:0]] <= c0;
    lrd_r <= lm_r[idx[LA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_addr_r <= cur_nxt;
      out_top_r  <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ddu_r <= 6'd32;  rdu_r <= 6'd32;  lsu_r <= 7'd64;  ifr_r <= 7'd0;
      ds_lim_r <= (DATA_DEPTH > 32)   ? DP_W'(32) : DP_W'(DATA_DEPTH);
      rs_lim_r <= (RETURN_DEPTH > 32) ? RP_W'(32) : RP_W'(RETURN_DEPTH);
      lv_lim_r <= (LOCAL_DEPTH > 64)  ? LM_W'(64) : LM_W'(LOCAL_DEPTH);
      dp_r     <= (DATA_DEPTH > 32)   ? DP_W'(32) : DP_W'(DATA_DEPTH);
      rp_r     <= '0;
      fb_r     <= '0;
      ftop_r   <= '0;
      halted_r <= ST_RUN;
      cur_r    <= '0;
      wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_st_r <= ST_RUN;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_DATA_DEPTH:   ddu_r <= cfg_ch.data[5:0];
          CFG_RETURN_DEPTH: rdu_r <= cfg_ch.data[5:0];
          CFG_LOCALS_SIZE:  lsu_r <= cfg_ch.data;
          CFG_INIT_FRAME:   ifr_r <= cfg_ch.data;
          default:          ddu_r <= ddu_r;
        endcase
      end
      wait_r <= wait_nxt;
      if (fire) begin
        ds_lim_r <= ds_lim_nxt;  rs_lim_r <= rs_lim_nxt;  lv_lim_r <= lv_lim_nxt;
        dp_r <= dp_nxt;  rp_r <= rp_nxt;  fb_r <= fb_nxt;  ftop_r <= ftop_nxt;
        halted_r <= halted_nxt;  cur_r <= cur_nxt;
        out_valid_r <= 1'b1;
        out_st_r <= halted_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_address = out_addr_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.top_value    = out_top_r;

`ifndef ASSERT_OFF
  a_dp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dp_r <= ds_lim_r) else $error("data pointer above its limit");
  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= rs_lim_r) else $error("return pointer above its limit");
  a_wait_lget: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r |-> (q_valid && q_item.op == OP_LGET && !q_item.bad))
    else $error("local read wait without a pending local get");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !q_item.bad && q_item.op == OP_START) |=>
    (halted_r == ST_RUN && dp_r == ds_lim_r && rp_r == '0))
    else $error("start did not reset the run state");
`endif

endmodule
`default_nettype wire

### rtl/core/stack_bytecode_executor.sv
// Top level of the stack bytecode executor.
// Connects the decoding front end and the executing back end; depends on sbe_pkg,
// sbe_channels, sbe_front and sbe_back.
//
// Usage: each in_ch transaction carries one fetched instruction; each produces exactly
// one out_ch transaction with the next address, the run status and the top data cell.
// Registers are written over cfg_ch, which is always ready; they take effect at the
// next start instruction; reset restores their defaults.
// An accepted instruction is written into the queue and then executed into the result
// register. One instruction completes per cycle while the receiver takes results; a
// local get within bounds first waits on the registered read port of the local store.
// A two-entry queue separates decode from execution, so instructions keep being
// accepted while a result waits. When the receiver stalls, the result register holds
// and the queue fills, then in_ch.ready drops.
// Reset empties the queue and the data stack, clears the return stack, the frame and
// the status, and restores the register defaults. Stack contents are not cleared.
`default_nettype none
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int DATA_DEPTH   = 32,
  parameter int RETURN_DEPTH = 32,
  parameter int LOCAL_DEPTH  = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sbe_in_if.sink    in_ch,
  sbe_out_if.source out_ch,
  sbe_cfg_if.sink   cfg_ch
);

  exec_item_t q_item;
  logic       q_valid, q_pop;

  sbe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  sbe_back #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH),
    .LOCAL_DEPTH  (LOCAL_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule
`default_nettype wire

### verif/stack_bytecode_executor_tb.sv
// Self-checking testbench of the stack bytecode executor.
// Drives instruction and register transactions; checks results via a predictor or fixed rows.
// Depends on sbe_pkg, sbe_channels and stack_bytecode_executor.
`default_nettype none
module stack_bytecode_executor_tb;
  import sbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] next_address;
    logic [2:0]  status;
    logic [15:0] top_value;
  } outcome_t;

  typedef struct {
    logic [5:0]  op;
    logic [31:0] imm;
    logic [7:0]  cf;
    logic [15:0] ft;
    bit          typed;
    outcome_t    want;
  } instr_row_t;

  logic clk;
  logic rst_n;
  sbe_in_if  in_ch();
  sbe_out_if out_ch();
  sbe_cfg_if cfg_ch();

  stack_bytecode_executor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  outcome_t pending_outcomes[$];
  int unsigned mismatch_count = 0;
  bit quiet = 0;
  bit hold_request = 0;

  // Machine state mirrored from the block.
  logic [5:0]  reg_data_depth = 6'd32, reg_return_depth = 6'd32;
  logic [6:0]  reg_locals_size = 7'd64, reg_init_frame = 7'd0;
  int unsigned ds_lim, rs_lim, lv_lim, dptr, rptr, fbase, ftop, halt_code, cur_addr;
  logic [15:0] data_mem[32];
  logic [15:0] ret_mem[32];
  logic [15:0] loc_mem[64];
  bit          loc_written[64];

  function automatic int unsigned clamp(int unsigned v, int unsigned m);
    return v > m ? m : v;
  endfunction

  function automatic void begin_run(logic [15:0] entry);
    ds_lim = clamp(reg_data_depth, 32);
    rs_lim = clamp(reg_return_depth, 32);
    lv_lim = clamp(reg_locals_size, 64);
    dptr = ds_lim;
    rptr = 0;
    fbase = 0;
    ftop = reg_init_frame;
    halt_code = ST_RUN;
    cur_addr = entry;
  endfunction

  function automatic bit has_cells(int unsigned n);
    return ds_lim - dptr >= n;
  endfunction

  function automatic bit push_cell(logic [15:0] v);
    if (dptr == 0 || dptr > ds_lim) return 0;
    dptr--;
    data_mem[dptr] = v;
    return 1;
  endfunction

  function automatic logic [31:0] cell_pair(int unsigned p);
    return {data_mem[p], data_mem[p + 1]};
  endfunction

  function automatic outcome_t execute_instruction(logic [5:0] op, logic [31:0] imm,
                                                   logic [7:0] cf, logic [15:0] ft);
    outcome_t o;
    int unsigned nip, st, p, idx;
    logic [31:0] a, b, x, y;
    nip = ft;
    st = ST_RUN;
    if (op == OP_START) begin
      begin_run(imm[15:0]);
    end else if (halt_code == ST_RUN) begin
      p = dptr;
      case (op)
        OP_BYE: st = has_cells(1) ? ST_DONE : ST_STACK;
        OP_ZERO, OP_S2D: if (!push_cell(16'd0)) st = ST_STACK;
        OP_ONE: if (!push_cell(16'd1)) st = ST_STACK;
        OP_LIT8: if (!push_cell({8'd0, imm[7:0]})) st = ST_STACK;
        OP_LIT16: if (!push_cell(imm[15:0])) st = ST_STACK;
        OP_DROP: if (!has_cells(1)) st = ST_STACK; else dptr++;
        OP_DUP: if (!has_cells(1) || !push_cell(data_mem[p])) st = ST_STACK;
        OP_SWAP: begin
          if (!has_cells(2)) st = ST_STACK;
          else begin
            a = data_mem[p];
            data_mem[p] = data_mem[p + 1];
            data_mem[p + 1] = a[15:0];
          end
        end
        OP_OVER: if (!has_cells(2) || !push_cell(data_mem[p + 1])) st = ST_STACK;
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_EQ, OP_NE, OP_ULT, OP_SLT: begin
          if (!has_cells(2)) st = ST_STACK;
          else begin
            a = data_mem[p + 1];
            b = data_mem[p];
            case (op)
              OP_ADD: x = a + b;
              OP_SUB: x = a - b;
              OP_AND: x = a & b;
              OP_OR:  x = a | b;
              OP_EQ:  x = 32'(a == b);
              OP_NE:  x = 32'(a != b);
              OP_ULT: x = 32'(a < b);
              default: x = 32'((a ^ 32'h8000) < (b ^ 32'h8000));
            endcase
            data_mem[p + 1] = x[15:0];
            dptr = p + 1;
          end
        end
        OP_INC: if (!has_cells(1)) st = ST_STACK; else data_mem[p] = data_mem[p] + 16'd1;
        OP_DEC: if (!has_cells(1)) st = ST_STACK; else data_mem[p] = data_mem[p] - 16'd1;
        OP_ZEQ: if (!has_cells(1)) st = ST_STACK; else data_mem[p] = 16'(data_mem[p] == 0);
        OP_JMP8, OP_JZ8, OP_JMP16, OP_JZ16: begin
          a = 0;
          if (op == OP_JZ8 || op == OP_JZ16) begin
            if (!has_cells(1)) st = ST_STACK;
            else begin
              a = data_mem[p];
              dptr = p + 1;
            end
          end
          if (st == ST_RUN && a == 0) begin
            if (op == OP_JMP8 || op == OP_JZ8) x = {{24{imm[7]}}, imm[7:0]};
            else x = imm;
            nip = (ft + x) & 32'hFFFF;
          end
        end
        OP_CALL: begin
          if (rptr + 2 > rs_lim) st = ST_STACK;
          else if (ftop + cf > lv_lim) st = ST_BOUNDS;
          else begin
            ret_mem[rptr++] = ft;
            ret_mem[rptr++] = fbase[15:0];
            fbase = ftop;
            ftop = (fbase + cf) & 32'hFF;
            nip = imm[15:0];
          end
        end
        OP_EXIT: begin
          if (rptr == 0) st = has_cells(1) ? ST_DONE : ST_STACK;
          else if (rptr < 2) st = ST_STACK;
          else begin
            ftop = fbase;
            fbase = ret_mem[--rptr] & 16'hFF;
            nip = ret_mem[--rptr];
          end
        end
        OP_TOR: begin
          if (!has_cells(1)) st = ST_STACK;
          else begin
            a = data_mem[p];
            dptr = p + 1;
            if (rptr >= rs_lim) st = ST_STACK;
            else ret_mem[rptr++] = a[15:0];
          end
        end
        OP_RFROM, OP_RFETCH: begin
          if (rptr == 0) st = ST_STACK;
          else begin
            a = ret_mem[rptr - 1];
            if (op == OP_RFROM) rptr--;
            if (!push_cell(a[15:0])) st = ST_STACK;
          end
        end
        OP_DLIT: if (!push_cell(imm[15:0]) || !push_cell(imm[31:16])) st = ST_STACK;
        OP_DDROP: if (!has_cells(2)) st = ST_STACK; else dptr = p + 2;
        OP_DADD, OP_DSUB, OP_DEQ, OP_DULT: begin
          if (!has_cells(4)) st = ST_STACK;
          else begin
            y = cell_pair(p);
            x = cell_pair(p + 2);
            if (op == OP_DADD || op == OP_DSUB) begin
              x = (op == OP_DADD) ? x + y : x - y;
              p += 2;
              data_mem[p + 1] = x[15:0];
              data_mem[p] = x[31:16];
            end else begin
              p += 3;
              data_mem[p] = (op == OP_DEQ) ? 16'(x == y) : 16'(x < y);
            end
            dptr = p;
          end
        end
        OP_LGET, OP_LSET: begin
          idx = fbase + imm[7:0];
          if (idx >= lv_lim) st = ST_BOUNDS;
          else if (op == OP_LGET) begin
            if (!push_cell(loc_mem[idx])) st = ST_STACK;
          end else if (!has_cells(1)) st = ST_STACK;
          else begin
            loc_mem[idx] = data_mem[p];
            loc_written[idx] = 1;
            dptr = p + 1;
          end
        end
        default: st = ST_BADOP;
      endcase
      if (st != ST_RUN) halt_code = st;
      else cur_addr = nip;
    end
    o.next_address = cur_addr[15:0];
    o.status = halt_code[2:0];
    o.top_value = (dptr < ds_lim) ? data_mem[dptr] : 16'd0;
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_register(logic [1:0] index, logic [6:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (index)
      CFG_DATA_DEPTH:   reg_data_depth = value[5:0];
      CFG_RETURN_DEPTH: reg_return_depth = value[5:0];
      CFG_LOCALS_SIZE:  reg_locals_size = value;
      default:          reg_init_frame = value;
    endcase
  endtask

  task automatic issue_instruction(instr_row_t row);
    outcome_t predicted;
    predicted = execute_instruction(row.op, row.imm, row.cf, row.ft);
    pending_outcomes.push_back(row.typed ? row.want : predicted);
    if (!quiet && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= row.op;
    in_ch.immediate <= row.imm;
    in_ch.callee_frame <= row.cf;
    in_ch.fall_through <= row.ft;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic instr_row_t random_instruction();
    instr_row_t row;
    int unsigned r;
    row.typed = 0;
    row.imm = $urandom();
    row.ft = 16'($urandom());
    row.cf = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (halt_code != ST_RUN && r < 70) row.op = OP_START;
    else if (r < 3) row.op = OP_START;
    else if (r < 6) row.op = 6'($urandom_range(OP_LAST + 1, 63));
    else if (r < 36) begin
      case ($urandom_range(0, 4))
        0: row.op = OP_ZERO;
        1: row.op = OP_ONE;
        2: row.op = OP_LIT8;
        3: row.op = OP_LIT16;
        default: row.op = OP_DLIT;
      endcase
    end else row.op = 6'($urandom_range(OP_BYE, OP_LAST));
    if (row.op == OP_START && $urandom_range(0, 1)) row.imm[15:0] = '0;
    if (row.op == OP_LGET || row.op == OP_LSET) begin
      if ($urandom_range(0, 9) != 0) row.imm[7:0] = 8'($urandom_range(0, 7));
      // A local that was never written must not be read.
      if (row.op == OP_LGET && halt_code == ST_RUN && fbase + row.imm[7:0] < lv_lim &&
          !loc_written[fbase + row.imm[7:0]])
        row.op = OP_LSET;
    end
    return row;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("stack_bytecode_executor test failed");
    $finish;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, address", out_ch.next_address, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.next_address !== want.next_address)
          report_mismatch("next_address", out_ch.next_address, want.next_address);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.top_value !== want.top_value)
          report_mismatch("top_value", out_ch.top_value, want.top_value);
      end
    end
  end

  initial begin
    bit held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 36);
    end
  end

  initial begin
    instr_row_t directed[$];
    instr_row_t row;
    logic [6:0] settings[5][4];
    int phase, n;
    directed = '{
      '{OP_DROP,  0,            0, 16'h0001, 1, '{16'h0000, ST_STACK, 16'h0000}},
      '{OP_START, 32'h0100,     0, 16'h0000, 1, '{16'h0100, ST_RUN, 16'h0000}},
      '{OP_LIT16, 32'h0000FFFF, 0, 16'h0103, 1, '{16'h0103, ST_RUN, 16'hFFFF}},
      '{OP_LIT8,  32'hFFFFFF80, 0, 16'h0105, 1, '{16'h0105, ST_RUN, 16'h0080}},
      '{OP_SLT,   0,            0, 16'h0106, 0, '{0, 0, 0}},
      '{OP_DLIT,  32'h8000FFFF, 0, 16'h010B, 0, '{0, 0, 0}},
      '{OP_DLIT,  32'h00000001, 0, 16'h0110, 0, '{0, 0, 0}},
      '{OP_DADD,  0,            0, 16'h0111, 0, '{0, 0, 0}},
      '{OP_DLIT,  32'hFFFFFFFF, 0, 16'h0116, 0, '{0, 0, 0}},
      '{OP_DULT,  0,            0, 16'h0117, 0, '{0, 0, 0}},
      '{OP_JZ8,   32'h000000FE, 0, 16'h0119, 0, '{0, 0, 0}},
      '{OP_CALL,  32'h00000400, 4, 16'h0120, 0, '{0, 0, 0}},
      '{OP_LIT8,  32'h00000007, 0, 16'h0402, 0, '{0, 0, 0}},
      '{OP_LSET,  32'h00000003, 0, 16'h0404, 0, '{0, 0, 0}},
      '{OP_LGET,  32'h00000003, 0, 16'h0406, 0, '{0, 0, 0}},
      '{OP_TOR,   0,            0, 16'h0407, 0, '{0, 0, 0}},
      '{OP_RFETCH, 0,           0, 16'h0408, 0, '{0, 0, 0}},
      '{OP_RFROM, 0,            0, 16'h0409, 0, '{0, 0, 0}},
      '{OP_EXIT,  0,            0, 16'h040A, 0, '{0, 0, 0}},
      '{OP_JMP16, 32'h0000FFF0, 0, 16'h0123, 0, '{0, 0, 0}},
      '{6'd63,    0,            0, 16'h0114, 0, '{0, 0, 0}},
      '{OP_START, 32'hFFFFFFFF, 0, 16'h0000, 1, '{16'hFFFF, ST_RUN, 16'h0000}},
      '{OP_EXIT,  0,            0, 16'h0001, 1, '{16'hFFFF, ST_STACK, 16'h0000}},
      '{OP_START, 0,            0, 16'h0000, 1, '{16'h0000, ST_RUN, 16'h0000}},
      '{OP_ONE,   0,            0, 16'h0001, 1, '{16'h0001, ST_RUN, 16'h0001}},
      '{OP_EXIT,  0,            0, 16'h0002, 1, '{16'h0001, ST_DONE, 16'h0001}}
    };
    settings = '{'{7'd63, 7'd63, 7'd127, 7'd127}, '{7'd0, 7'd0, 7'd0, 7'd0},
                 '{7'd1, 7'd2, 7'd1, 7'd0}, '{7'd32, 7'd32, 7'd64, 7'd64},
                 '{7'd8, 7'd6, 7'd16, 7'd4}};
    begin_run(0);
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_START;
    in_ch.immediate <= '0;
    in_ch.callee_frame <= '0;
    in_ch.fall_through <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_DATA_DEPTH;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) issue_instruction(directed[i]);
    for (phase = 0; phase < 6; phase++) begin
      in_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clk);
      if (phase < 5) begin
        write_register(CFG_DATA_DEPTH, settings[phase][0]);
        write_register(CFG_RETURN_DEPTH, settings[phase][1]);
        write_register(CFG_LOCALS_SIZE, settings[phase][2]);
        write_register(CFG_INIT_FRAME, settings[phase][3]);
      end else begin
        write_register(CFG_DATA_DEPTH, 7'($urandom_range(1, 32)));
        write_register(CFG_RETURN_DEPTH, 7'($urandom_range(2, 32)));
        write_register(CFG_LOCALS_SIZE, 7'($urandom_range(8, 64)));
        write_register(CFG_INIT_FRAME, 7'($urandom_range(0, 8)));
      end
      n = (phase == 1) ? 60 : 240;
      for (int k = 0; k < n; k++) begin
        quiet = (phase == 3 && k >= 40 && k < 140);
        if (phase == 4 && k == 20) hold_request = 1;
        if (k == 0) row = instr_row_t'{OP_START, $urandom(), 8'd0, 16'h0000, 1'b0,
                                       '{16'd0, 3'd0, 16'd0}};
        else row = random_instruction();
        issue_instruction(row);
      end
      quiet = 0;
    end
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("stack_bytecode_executor test passed");
    end else begin
      $display("stack_bytecode_executor test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
